>>> hdl/eepfr_pkg.sv
`default_nettype none
package eepfr_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [3:0] CHIP_KIND_RESET = 4'd1;
	localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'd160;
	// kinds above this one send two address bytes
	localparam logic [3:0] LAST_SMALL_KIND = 4'd4;

	localparam logic CFG_CHIP_KIND = 1'b0;
	localparam logic CFG_DEVICE_ADDRESS = 1'b1;

	typedef enum logic [2:0] {
		OP_START = 3'd0,
		OP_SEND = 3'd1,
		OP_READ_ACK = 3'd2,
		OP_READ_NACK = 3'd3,
		OP_STOP = 3'd4
	} bus_op_t;

	// bus operation slots of one item, in emission order
	localparam int NUM_SLOTS = 8;
	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam logic [SLOT_W-1:0] SLOT_START = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_DEV = 3'd1;
	localparam logic [SLOT_W-1:0] SLOT_HI = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_LO = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_RSTART = 3'd4;
	localparam logic [SLOT_W-1:0] SLOT_RDEV = 3'd5;
	localparam logic [SLOT_W-1:0] SLOT_MAIN = 3'd6;
	localparam logic [SLOT_W-1:0] SLOT_STOP = 3'd7;

	typedef struct packed {
		logic [NUM_SLOTS-1:0] slots;
		logic [7:0] dev_byte;
		logic [7:0] hi_byte;
		logic [7:0] lo_byte;
		logic [7:0] rdev_byte;
		logic [7:0] main_byte;
		bus_op_t main_op;
	} desc_t;

	// page size minus one per chip kind
	function automatic logic [15:0] page_mask(input logic [3:0] kind);
		logic [15:0] m;
		unique case (kind)
			4'd0, 4'd1: m = 16'd7;
			4'd2, 4'd3, 4'd4: m = 16'd15;
			4'd5, 4'd6: m = 16'd31;
			4'd7, 4'd8: m = 16'd63;
			4'd9: m = 16'd127;
			default: m = 16'd255;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

>>> hdl/eepfr_front.sv
`default_nettype none
module eepfr_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic cfg_index,
	input wire logic [7:0] cfg_data,
	input wire logic push,
	input wire logic q_full,
	input wire logic req_type,
	input wire logic [15:0] start_address,
	input wire logic first_of_burst,
	input wire logic last_of_burst,
	input wire logic [7:0] data_byte,
	output logic q_wr,
	output eepfr_pkg::desc_t q_wr_desc
);
	import eepfr_pkg::*;

	logic [3:0] chip_kind_q;
	logic [7:0] device_address_q;
	logic [15:0] next_address_q;

	logic [15:0] addr_cur;
	logic [15:0] addr_nxt;
	logic [15:0] mask;
	logic wide_addr;
	logic hdr;
	logic stop;
	logic rd_hdr;

	assign q_wr = push & ~q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_kind_q <= CHIP_KIND_RESET;
			device_address_q <= DEVICE_ADDRESS_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_CHIP_KIND: chip_kind_q <= cfg_data[3:0];
				CFG_DEVICE_ADDRESS: device_address_q <= cfg_data;
			endcase
		end
	end

	always_comb begin
		addr_cur = first_of_burst ? start_address : next_address_q;
		addr_nxt = addr_cur + 16'd1;
		mask = page_mask(chip_kind_q);
		wide_addr = chip_kind_q > LAST_SMALL_KIND;
		if (req_type) begin
			hdr = first_of_burst;
			stop = last_of_burst;
		end else begin
			hdr = first_of_burst | ((addr_cur & mask) == 16'd0);
			stop = last_of_burst | ((addr_nxt & mask) == 16'd0);
		end
		rd_hdr = req_type & first_of_burst;

		q_wr_desc = '0;
		q_wr_desc.slots[SLOT_START] = hdr;
		q_wr_desc.slots[SLOT_DEV] = hdr;
		q_wr_desc.slots[SLOT_HI] = hdr & wide_addr;
		q_wr_desc.slots[SLOT_LO] = hdr;
		q_wr_desc.slots[SLOT_RSTART] = rd_hdr;
		q_wr_desc.slots[SLOT_RDEV] = rd_hdr;
		q_wr_desc.slots[SLOT_MAIN] = 1'b1;
		q_wr_desc.slots[SLOT_STOP] = stop;
		// small chips fold address bits 8 to 14 into the device byte
		q_wr_desc.dev_byte = wide_addr ? device_address_q
			: device_address_q + {addr_cur[14:8], 1'b0};
		q_wr_desc.hi_byte = addr_cur[15:8];
		q_wr_desc.lo_byte = addr_cur[7:0];
		q_wr_desc.rdev_byte = device_address_q + 8'd1;
		q_wr_desc.main_byte = req_type ? 8'd0 : data_byte;
		if (!req_type)
			q_wr_desc.main_op = OP_SEND;
		else if (last_of_burst)
			q_wr_desc.main_op = OP_READ_NACK;
		else
			q_wr_desc.main_op = OP_READ_ACK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_address_q <= 16'd0;
		end else if (q_wr) begin
			next_address_q <= addr_nxt;
		end
	end

endmodule
`default_nettype wire

>>> hdl/eepfr_queue.sv
`default_nettype none
module eepfr_queue #(
	parameter int DEPTH = eepfr_pkg::QUEUE_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr,
	input wire eepfr_pkg::desc_t wr_desc,
	input wire logic rd,
	output logic q_full,
	output logic q_empty,
	output eepfr_pkg::desc_t rd_desc
);
	import eepfr_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	desc_t mem [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign q_full = count_q == CW'(DEPTH);
	assign q_empty = count_q == '0;
	assign rd_desc = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem[wr_ptr_q] <= wr_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (rd)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (wr && !rd)
				count_q <= count_q + CW'(1);
			else if (rd && !wr)
				count_q <= count_q - CW'(1);
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr && q_full && !rd)) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> !q_empty) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

>>> hdl/eepfr_back.sv
`default_nettype none
module eepfr_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_empty,
	input wire eepfr_pkg::desc_t rd_desc,
	output logic q_rd,
	input wire logic pop,
	output logic empty,
	output logic [2:0] bus_op,
	output logic [7:0] bus_byte,
	output logic last_of_run
);
	import eepfr_pkg::*;

	desc_t cur_q;
	logic [NUM_SLOTS-1:0] slots_q;
	logic out_valid_q;
	bus_op_t out_op_q;
	logic [7:0] out_byte_q;
	logic out_last_q;

	logic out_free;
	logic adv;
	logic found;
	logic [SLOT_W-1:0] sel;
	logic [NUM_SLOTS-1:0] slots_after;
	bus_op_t sel_op;
	logic [7:0] sel_byte;

	assign out_free = ~out_valid_q | pop;
	assign adv = out_free & (slots_q != '0);

	always_comb begin
		sel = '0;
		found = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (slots_q[i] && !found) begin
				sel = SLOT_W'(i);
				found = 1'b1;
			end
		end
		slots_after = adv ? (slots_q & ~(NUM_SLOTS'(1) << sel)) : slots_q;
	end

	// fetch the next item once the current one has issued its final operation
	assign q_rd = ~q_empty & (slots_after == '0);

	always_comb begin
		sel_op = OP_SEND;
		sel_byte = 8'd0;
		unique case (sel)
			SLOT_START, SLOT_RSTART: sel_op = OP_START;
			SLOT_DEV: sel_byte = cur_q.dev_byte;
			SLOT_HI: sel_byte = cur_q.hi_byte;
			SLOT_LO: sel_byte = cur_q.lo_byte;
			SLOT_RDEV: sel_byte = cur_q.rdev_byte;
			SLOT_MAIN: begin
				sel_op = cur_q.main_op;
				sel_byte = cur_q.main_byte;
			end
			SLOT_STOP: sel_op = OP_STOP;
			default: sel_op = OP_STOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			slots_q <= q_rd ? rd_desc.slots : slots_after;
			if (adv)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd)
			cur_q <= rd_desc;
		if (adv) begin
			out_op_q <= sel_op;
			out_byte_q <= sel_byte;
			out_last_q <= slots_after == '0;
		end
	end

	assign empty = ~out_valid_q;
	assign bus_op = out_op_q;
	assign bus_byte = out_byte_q;
	assign last_of_run = out_last_q;

`ifndef ASSERT_OFF
	a_load_active: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |=> slots_q != '0) else $error("item loaded with no operations");
	a_last_marks_end: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q && (out_last_q == ($past(slots_after) == '0)))
		else $error("last_of_run out of step with slot mask");
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_op_q != OP_SEND) |-> out_byte_q == 8'd0)
		else $error("nonzero byte on non-send operation");
`endif

endmodule
`default_nettype wire

>>> hdl/i2c_eeprom_transfer_framer_core.sv
// 24Cxx EEPROM transfer framer.
// Input side is a queue: present one burst byte with push, it is taken when
// full is low. Result side is a queue of bus operations (start, send byte,
// read ack, read nack, stop): the oldest sits on bus_op/bus_byte/last_of_run
// while empty is low and leaves on pop. last_of_run flags the final
// operation of each input item.
// Config: cfg_write with cfg_index 0 sets chip_kind, 1 sets device_address;
// write only while the block is idle.
// The front end computes page framing and the running address at accept
// time and queues a per-item descriptor (2 deep); the back end issues one
// bus operation per cycle from it into a single output register while pop
// keeps that register free. An item's first operation passes through the
// descriptor queue, the back end's slot register and the output register.
// Throughput: one bus operation per cycle while pop keeps up; an item has
// 1 to 8 operations, and items are accepted every cycle while the
// descriptor queue has room. A stall on pop holds the output register, then
// the descriptor queue fills and full rises. Reset clears both queues, the
// address to 0, chip kind to 1 and the device address to 160.
`default_nettype none
module i2c_eeprom_transfer_framer_core #(
	parameter int QUEUE_DEPTH = eepfr_pkg::QUEUE_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic cfg_index,
	input wire logic [7:0] cfg_data,
	input wire logic push,
	output logic full,
	input wire logic req_type,
	input wire logic [15:0] start_address,
	input wire logic first_of_burst,
	input wire logic last_of_burst,
	input wire logic [7:0] data_byte,
	output logic empty,
	input wire logic pop,
	output logic [2:0] bus_op,
	output logic [7:0] bus_byte,
	output logic last_of_run
);
	import eepfr_pkg::*;

	logic q_wr;
	logic q_rd;
	logic q_empty;
	desc_t wr_desc;
	desc_t rd_desc;

	eepfr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.q_full(full),
		.req_type(req_type),
		.start_address(start_address),
		.first_of_burst(first_of_burst),
		.last_of_burst(last_of_burst),
		.data_byte(data_byte),
		.q_wr(q_wr),
		.q_wr_desc(wr_desc)
	);

	eepfr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(q_wr),
		.wr_desc(wr_desc),
		.rd(q_rd),
		.q_full(full),
		.q_empty(q_empty),
		.rd_desc(rd_desc)
	);

	eepfr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.rd_desc(rd_desc),
		.q_rd(q_rd),
		.pop(pop),
		.empty(empty),
		.bus_op(bus_op),
		.bus_byte(bus_byte),
		.last_of_run(last_of_run)
	);

endmodule
`default_nettype wire
